/* src/bcm_pkg.sv */
`default_nettype none
package bcm_pkg;

   localparam int MAX_ENTRIES  = 256;
   localparam int BLOCK_WORDS  = 32;
   localparam int IDX_W        = $clog2(MAX_ENTRIES);
   localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
   localparam int WIDX_W       = $clog2(BLOCK_WORDS);
   localparam int LEN_W        = $clog2(BLOCK_WORDS + 1);
   localparam int TAG_W        = 12;
   localparam int STAMP_W      = 32;
   localparam int WORD_W       = 64;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int MIN_ENTRIES  = 2;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;

   localparam logic CSR_ENABLE  = 1'b0;
   localparam logic CSR_ENTRIES = 1'b1;

   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_MISS = 3'd1,
      ST_BAD  = 3'd2,
      ST_DUP  = 3'd3,
      ST_OFF  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_INSERT,
      OP_UPDATE,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [3:0]        disk_id;
      logic [7:0]        block_id;
      logic [WORD_W-1:0] data_word;
      logic              last_word;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] read_word;
      logic              run_last;
      logic [31:0]       hit_total;
      logic [31:0]       query_total;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [TAG_W-1:0]  tag;
      logic [WORD_W-1:0] word;
      logic              last;
   } task_type;

   typedef struct packed {
      logic             enable;
      logic [CNT_W-1:0] entries;
   } cfg_type;

endpackage
`default_nettype wire

/* src/bcm_ram.sv */
`default_nettype none
module bcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

/* src/bcm_front.sv */
`default_nettype none
module bcm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire bcm_pkg::req_type req_data,
   output logic                  head_valid,
   output bcm_pkg::task_type     head,
   input  wire logic             head_take
);

   bcm_pkg::task_type                 queue_ff [bcm_pkg::FIFO_DEPTH];
   logic [bcm_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bcm_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bcm_pkg::FIFO_PTR_W:0]      count_ff, count_in;
   bcm_pkg::task_type                 classified;
   logic                              do_push, do_pop;

   // classify: disk and block fields span the geometry exactly, so no range fault
   always_comb begin
      case (req_data.mode)
         bcm_pkg::MODE_LOOKUP: classified.op = bcm_pkg::OP_LOOKUP;
         bcm_pkg::MODE_INSERT: classified.op = bcm_pkg::OP_INSERT;
         bcm_pkg::MODE_UPDATE: classified.op = bcm_pkg::OP_UPDATE;
         default:              classified.op = bcm_pkg::OP_BAD;
      endcase
      classified.tag  = {req_data.disk_id, req_data.block_id};
      classified.word = req_data.data_word;
      classified.last = req_data.last_word;
   end

   assign full       = (count_ff == (bcm_pkg::FIFO_PTR_W+1)'(bcm_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_take && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule
`default_nettype wire

/* src/bcm_back.sv */
`default_nettype none
module bcm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcm_pkg::cfg_type  cfg,
   input  wire logic              head_valid,
   input  wire bcm_pkg::task_type head,
   output logic                   head_take,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output bcm_pkg::rsp_type       rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_LEN, S_WORD, S_EMIT, S_STREAM_RD, S_STREAM_OUT
   } state_type;

   localparam int BLK_DEPTH = bcm_pkg::MAX_ENTRIES * bcm_pkg::BLOCK_WORDS;
   localparam int BLK_AW    = $clog2(BLK_DEPTH);

   state_type                        state_ff;
   bcm_pkg::task_type                task_ff;
   logic                             run_active_ff;
   bcm_pkg::op_type                  run_mode_ff;
   bcm_pkg::status_type              run_status_ff;
   bcm_pkg::status_type              emit_status_ff;
   logic [bcm_pkg::IDX_W-1:0]        pending_ff;
   logic [bcm_pkg::WIDX_W-1:0]       wc_ff;
   logic [bcm_pkg::LEN_W-1:0]        run_len_ff;
   logic [bcm_pkg::LEN_W-1:0]        hit_len_ff;
   logic [bcm_pkg::WIDX_W-1:0]       k_ff;
   logic [bcm_pkg::STAMP_W-1:0]      clock_ff;
   logic [31:0]                      hit_ff, query_ff;
   logic [bcm_pkg::CNT_W-1:0]        issue_ff;
   logic                             rd_pend_ff;
   logic [bcm_pkg::IDX_W-1:0]        rd_idx_ff;
   logic                             match_found_ff, inv_found_ff;
   logic [bcm_pkg::IDX_W-1:0]        match_idx_ff, inv_idx_ff, best_idx_ff;
   logic [bcm_pkg::STAMP_W-1:0]      best_stamp_ff;
   logic [bcm_pkg::MAX_ENTRIES-1:0]  valid_ff;
   logic                             rsp_valid_ff;
   bcm_pkg::rsp_type                 rsp_ff;

   logic [bcm_pkg::CNT_W-1:0]        n_active;
   logic [bcm_pkg::IDX_W-1:0]        ins_slot;
   logic [bcm_pkg::LEN_W-1:0]        wc_len;
   logic [bcm_pkg::LEN_W-1:0]        new_len;
   logic                             run_end;

   logic                             tag_we, stamp_we, len_we, blk_we;
   logic [bcm_pkg::IDX_W-1:0]        meta_waddr, len_waddr;
   logic [bcm_pkg::STAMP_W-1:0]      stamp_wdata;
   logic [bcm_pkg::LEN_W-1:0]        len_wdata;
   logic [bcm_pkg::TAG_W-1:0]        tag_rdata;
   logic [bcm_pkg::STAMP_W-1:0]      stamp_rdata;
   logic [bcm_pkg::LEN_W-1:0]        len_rdata;
   logic [bcm_pkg::WORD_W-1:0]       blk_rdata;

   always_comb begin
      n_active = cfg.entries;
      if (cfg.entries < bcm_pkg::CNT_W'(bcm_pkg::MIN_ENTRIES)) begin
         n_active = bcm_pkg::CNT_W'(bcm_pkg::MIN_ENTRIES);
      end else if (cfg.entries > bcm_pkg::CNT_W'(bcm_pkg::MAX_ENTRIES)) begin
         n_active = bcm_pkg::CNT_W'(bcm_pkg::MAX_ENTRIES);
      end
   end

   assign ins_slot  = inv_found_ff ? inv_idx_ff : best_idx_ff;
   assign wc_len    = {1'b0, wc_ff} + 1'b1;
   assign new_len   = (wc_len > run_len_ff) ? wc_len : run_len_ff;
   assign run_end   = task_ff.last || (wc_ff == bcm_pkg::WIDX_W'(bcm_pkg::BLOCK_WORDS - 1));
   assign head_take = (state_ff == S_IDLE) && head_valid;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      tag_we      = 1'b0;
      stamp_we    = 1'b0;
      len_we      = 1'b0;
      blk_we      = 1'b0;
      meta_waddr  = match_idx_ff;
      len_waddr   = pending_ff;
      stamp_wdata = clock_ff;
      len_wdata   = new_len;
      case (state_ff)
         S_DECIDE: begin
            case (task_ff.op)
               bcm_pkg::OP_LOOKUP, bcm_pkg::OP_UPDATE: begin
                  stamp_we = match_found_ff;
               end
               bcm_pkg::OP_INSERT: begin
                  tag_we      = !match_found_ff;
                  stamp_we    = !match_found_ff;
                  len_we      = !match_found_ff;
                  meta_waddr  = ins_slot;
                  len_waddr   = ins_slot;
                  stamp_wdata = clock_ff + 1'b1;
                  len_wdata   = '0;
               end
               default: ;
            endcase
         end
         S_WORD: begin
            blk_we = (run_status_ff == bcm_pkg::ST_OK);
            len_we = (run_status_ff == bcm_pkg::ST_OK);
         end
         default: ;
      endcase
   end

   bcm_ram #(.WIDTH(bcm_pkg::TAG_W), .DEPTH(bcm_pkg::MAX_ENTRIES)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (meta_waddr),
      .wdata (task_ff.tag),
      .raddr (issue_ff[bcm_pkg::IDX_W-1:0]),
      .rdata (tag_rdata)
   );

   bcm_ram #(.WIDTH(bcm_pkg::STAMP_W), .DEPTH(bcm_pkg::MAX_ENTRIES)) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (meta_waddr),
      .wdata (stamp_wdata),
      .raddr (issue_ff[bcm_pkg::IDX_W-1:0]),
      .rdata (stamp_rdata)
   );

   bcm_ram #(.WIDTH(bcm_pkg::LEN_W), .DEPTH(bcm_pkg::MAX_ENTRIES)) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .raddr (match_idx_ff),
      .rdata (len_rdata)
   );

   bcm_ram #(.WIDTH(bcm_pkg::WORD_W), .DEPTH(BLK_DEPTH)) u_blk_ram (
      .clock (clock),
      .we    (blk_we),
      .waddr (BLK_AW'({pending_ff, wc_ff})),
      .wdata (task_ff.word),
      .raddr (BLK_AW'({match_idx_ff, k_ff})),
      .rdata (blk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_active_ff  <= 1'b0;
         run_mode_ff    <= bcm_pkg::OP_LOOKUP;
         run_status_ff  <= bcm_pkg::ST_OK;
         wc_ff          <= '0;
         pending_ff     <= '0;
         clock_ff       <= '0;
         hit_ff         <= '0;
         query_ff       <= '0;
         rd_pend_ff     <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  task_ff <= head;
                  if (!cfg.enable) begin
                     run_active_ff  <= 1'b0;
                     wc_ff          <= '0;
                     emit_status_ff <= bcm_pkg::ST_OFF;
                     state_ff       <= S_EMIT;
                  end else if (run_active_ff && head.op == run_mode_ff) begin
                     state_ff <= S_WORD;
                  end else begin
                     run_active_ff <= 1'b0;
                     wc_ff         <= '0;
                     if (head.op == bcm_pkg::OP_BAD) begin
                        emit_status_ff <= bcm_pkg::ST_BAD;
                        state_ff       <= S_EMIT;
                     end else begin
                        issue_ff       <= '0;
                        rd_pend_ff     <= 1'b0;
                        match_found_ff <= 1'b0;
                        inv_found_ff   <= 1'b0;
                        state_ff       <= S_SCAN;
                     end
                  end
               end
            end
            S_SCAN: begin
               // issue one entry read a cycle, evaluate the one read last cycle
               if (issue_ff < n_active) begin
                  issue_ff   <= issue_ff + 1'b1;
                  rd_pend_ff <= 1'b1;
                  rd_idx_ff  <= issue_ff[bcm_pkg::IDX_W-1:0];
               end else begin
                  rd_pend_ff <= 1'b0;
                  if (!rd_pend_ff) begin
                     state_ff <= S_DECIDE;
                  end
               end
               if (rd_pend_ff) begin
                  if (valid_ff[rd_idx_ff] && tag_rdata == task_ff.tag && !match_found_ff) begin
                     match_found_ff <= 1'b1;
                     match_idx_ff   <= rd_idx_ff;
                  end
                  if (!valid_ff[rd_idx_ff] && !inv_found_ff) begin
                     inv_found_ff <= 1'b1;
                     inv_idx_ff   <= rd_idx_ff;
                  end
                  if (rd_idx_ff == '0 || stamp_rdata > best_stamp_ff) begin
                     best_stamp_ff <= stamp_rdata;
                     best_idx_ff   <= rd_idx_ff;
                  end
               end
            end
            S_DECIDE: begin
               case (task_ff.op)
                  bcm_pkg::OP_LOOKUP: begin
                     query_ff <= query_ff + 1'b1;
                     if (match_found_ff) begin
                        hit_ff   <= hit_ff + 1'b1;
                        clock_ff <= clock_ff + 1'b1;
                        k_ff     <= '0;
                        state_ff <= S_LEN;
                     end else begin
                        emit_status_ff <= bcm_pkg::ST_MISS;
                        state_ff       <= S_EMIT;
                     end
                  end
                  bcm_pkg::OP_INSERT: begin
                     run_active_ff <= 1'b1;
                     run_mode_ff   <= bcm_pkg::OP_INSERT;
                     state_ff      <= S_WORD;
                     if (match_found_ff) begin
                        run_status_ff <= bcm_pkg::ST_DUP;
                     end else begin
                        run_status_ff      <= bcm_pkg::ST_OK;
                        clock_ff           <= clock_ff + 1'b1;
                        valid_ff[ins_slot] <= 1'b1;
                        pending_ff         <= ins_slot;
                        run_len_ff         <= '0;
                     end
                  end
                  default: begin
                     run_active_ff <= 1'b1;
                     run_mode_ff   <= bcm_pkg::OP_UPDATE;
                     if (match_found_ff) begin
                        run_status_ff <= bcm_pkg::ST_OK;
                        pending_ff    <= match_idx_ff;
                        clock_ff      <= clock_ff + 1'b1;
                        state_ff      <= S_LEN;
                     end else begin
                        run_status_ff <= bcm_pkg::ST_MISS;
                        state_ff      <= S_WORD;
                     end
                  end
               endcase
            end
            S_LEN: begin
               if (task_ff.op == bcm_pkg::OP_LOOKUP) begin
                  hit_len_ff <= len_rdata;
                  state_ff   <= S_STREAM_RD;
               end else begin
                  run_len_ff <= len_rdata;
                  state_ff   <= S_WORD;
               end
            end
            S_WORD: begin
               if (run_status_ff == bcm_pkg::ST_OK) begin
                  run_len_ff <= new_len;
               end
               if (run_end) begin
                  run_active_ff  <= 1'b0;
                  wc_ff          <= '0;
                  emit_status_ff <= run_status_ff;
                  state_ff       <= S_EMIT;
               end else begin
                  wc_ff    <= wc_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= emit_status_ff;
                  rsp_ff.read_word   <= '0;
                  rsp_ff.run_last    <= 1'b1;
                  rsp_ff.hit_total   <= hit_ff;
                  rsp_ff.query_total <= query_ff;
                  state_ff           <= S_IDLE;
               end
            end
            S_STREAM_RD: begin
               state_ff <= S_STREAM_OUT;
            end
            S_STREAM_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= bcm_pkg::ST_OK;
                  // words past the filled prefix read as zero
                  rsp_ff.read_word   <= ({1'b0, k_ff} < hit_len_ff) ? blk_rdata : '0;
                  rsp_ff.run_last    <= (k_ff == bcm_pkg::WIDX_W'(bcm_pkg::BLOCK_WORDS - 1));
                  rsp_ff.hit_total   <= hit_ff;
                  rsp_ff.query_total <= query_ff;
                  if (k_ff == bcm_pkg::WIDX_W'(bcm_pkg::BLOCK_WORDS - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_STREAM_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/block_cache_mru_replace.sv */
`default_nettype none
// Fully associative cache of 32-word disk blocks with most-recently-used
// replacement. Items enter a four-deep queue (req_push/req_full) and a back
// engine executes them one at a time; results leave through a one-item output
// register (rsp_empty/rsp_pop). An accepted item waits in the queue registers
// until the back engine is idle and takes it. A payload word that continues an
// insert or update run goes from idle straight to its word write, and when it
// ends the run it also returns its item through the emit step. A lookup, or
// the word that starts a run, first scans the tag and stamp memories one entry
// a cycle over the entries register value clamped to 2..256. A decide step
// then returns a miss or makes the first insert write; an update first reads
// the entry's fill length, and a lookup hit reads it and then its first word.
// A hit then streams its 32 words, each read from the block memory and
// registered as rsp_pop frees the output register. A per-entry fill length
// stands for the zeroing of a newly inserted block, so there is no clearing
// pass after reset. Write the csr registers only while the block is idle.
module block_cache_mru_replace (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire bcm_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output bcm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [8:0]       csr_wdata
);

   bcm_pkg::cfg_type  cfg_ff;
   logic              head_valid;
   logic              head_take;
   bcm_pkg::task_type head;

   // hold the configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable  <= 1'b0;
         cfg_ff.entries <= bcm_pkg::CNT_W'(bcm_pkg::MIN_ENTRIES);
      end else if (csr_we) begin
         case (csr_index)
            bcm_pkg::CSR_ENABLE:  cfg_ff.enable  <= csr_wdata[0];
            bcm_pkg::CSR_ENTRIES: cfg_ff.entries <= bcm_pkg::CNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // front: accept and classify items into the queue
   bcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   // back: search, replace, write payload and stream results
   bcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* src/bcm_checker.sv */
`default_nettype none
module bcm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire bcm_pkg::rsp_type rsp_data
);

   logic        stream_ff;
   logic [31:0] hit_seen_ff;

   // track whether the last item taken was a non-final word of a block stream
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ff   <= 1'b0;
         hit_seen_ff <= '0;
      end else if (!rsp_empty && rsp_pop) begin
         stream_ff   <= !rsp_data.run_last;
         hit_seen_ff <= rsp_data.hit_total;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting item changed");

   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != bcm_pkg::ST_OK |-> rsp_data.run_last)
      else $error("failed operation not a single item");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != bcm_pkg::ST_OK |-> rsp_data.read_word == '0)
      else $error("failed operation carries data");

   a_counters: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && stream_ff |-> rsp_data.hit_total == hit_seen_ff)
      else $error("hit count moved inside a block stream");

endmodule

bind block_cache_mru_replace bcm_checker u_bcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire
